// ===== rtl/spilcd_pkg.sv =====
// Shared types, opcodes, color tables and helpers for the SPI LCD command decoder.
package spilcd_pkg;

  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 320;
  localparam int unsigned PARAM_STORE   = 16;

  localparam logic [15:0] SCREEN_W = 16'(SCREEN_WIDTH);
  localparam logic [15:0] SCREEN_H = 16'(SCREEN_HEIGHT);
  localparam logic [15:0] FULL_X1  = 16'(SCREEN_WIDTH - 1);
  localparam logic [15:0] FULL_Y1  = 16'(SCREEN_HEIGHT - 1);
  localparam logic [4:0]  PARAM_LIMIT = 5'(PARAM_STORE);

  // Command opcodes.
  localparam logic [7:0] OP_SWRESET  = 8'h01;
  localparam logic [7:0] OP_SLPIN    = 8'h10;
  localparam logic [7:0] OP_SLPOUT   = 8'h11;
  localparam logic [7:0] OP_INVOFF   = 8'h20;
  localparam logic [7:0] OP_INVON    = 8'h21;
  localparam logic [7:0] OP_DISPOFF  = 8'h28;
  localparam logic [7:0] OP_DISPON   = 8'h29;
  localparam logic [7:0] OP_CASET    = 8'h2a;
  localparam logic [7:0] OP_RASET    = 8'h2b;
  localparam logic [7:0] OP_RAMWR    = 8'h2c;
  localparam logic [7:0] OP_VSCRDEF  = 8'h33;
  localparam logic [7:0] OP_MADCTL   = 8'h36;
  localparam logic [7:0] OP_VSCSAD   = 8'h37;
  localparam logic [7:0] OP_COLMOD   = 8'h3a;
  localparam logic [7:0] OP_FRMCTR1  = 8'hb1;
  localparam logic [7:0] OP_INVCTR   = 8'hb4;
  localparam logic [7:0] OP_DFUNCTR  = 8'hb6;
  localparam logic [7:0] OP_ETMOD    = 8'hb7;
  localparam logic [7:0] OP_PWCTR1   = 8'hc0;
  localparam logic [7:0] OP_PWCTR2   = 8'hc1;
  localparam logic [7:0] OP_VMCTR1   = 8'hc5;
  localparam logic [7:0] OP_VMOFCTR  = 8'hc7;
  localparam logic [7:0] OP_PGAMCTRL = 8'he0;
  localparam logic [7:0] OP_NGAMCTRL = 8'he1;
  localparam logic [7:0] OP_PUMPCTL  = 8'hf7;

  localparam logic [7:0]  FMT_RGB565    = 8'h55;
  localparam logic [31:0] HASH_PRIME    = 32'd16777619;
  localparam logic [31:0] HASH_SEED_RST = 32'd2166136261;

  // Register index of hash_seed on the configuration port.
  localparam logic REG_HASH_SEED = 1'b0;

  typedef struct packed {
    logic       deselected;
    logic       command;
    logic [7:0] spi_byte;
  } item_t;

  typedef struct packed {
    logic  step;
    item_t item;
  } step_t;

  typedef struct packed {
    logic        load;
    logic [31:0] value;
  } seed_load_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic        pixel_valid;
    logic        in_bounds;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    color_t      color;
    logic [31:0] run_hash;
    logic        sleeping;
    logic        display_enabled;
    logic        inverted;
    logic [7:0]  orientation;
  } result_t;

  typedef logic [31:0][7:0] exp5_tbl_t;
  typedef logic [63:0][7:0] exp6_tbl_t;

  // Rounded widening of 5-bit and 6-bit channels to 8 bits.
  function automatic exp5_tbl_t build_exp5();
    exp5_tbl_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255 + 15) / 31);
    end
    return t;
  endfunction

  function automatic exp6_tbl_t build_exp6();
    exp6_tbl_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255 + 31) / 63);
    end
    return t;
  endfunction

  localparam exp5_tbl_t EXP5 = build_exp5();
  localparam exp6_tbl_t EXP6 = build_exp6();

  // Number of parameter bytes an opcode takes; zero for immediate or unknown opcodes.
  function automatic logic [3:0] fixed_count(logic [7:0] op);
    logic [3:0] n;
    unique case (op) inside
      OP_CASET, OP_RASET, OP_PUMPCTL:                       n = 4'd4;
      OP_MADCTL, OP_COLMOD, OP_INVCTR, OP_ETMOD,
      OP_PWCTR2, OP_VMOFCTR:                                n = 4'd1;
      OP_VSCRDEF:                                           n = 4'd6;
      OP_VSCSAD, OP_FRMCTR1, OP_PWCTR1:                     n = 4'd2;
      OP_DFUNCTR, OP_VMCTR1:                                n = 4'd3;
      OP_PGAMCTRL, OP_NGAMCTRL:                             n = 4'd15;
      default:                                              n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/spilcd_color.sv =====
// Pixel color assembly: RGB565 widening or direct 8-bit channels.
module spilcd_color
  import spilcd_pkg::*;
(
  input  logic       rgb565,
  input  logic [7:0] hold0,
  input  logic [7:0] hold1,
  input  logic [7:0] last_byte,
  output color_t     color
);

  logic [4:0] r5;
  logic [5:0] g6;
  logic [4:0] b5;

  assign r5 = hold0[7:3];
  assign g6 = {hold0[2:0], last_byte[7:5]};
  assign b5 = last_byte[4:0];

  always_comb begin
    if (rgb565) begin
      color.red   = EXP5[r5];
      color.green = EXP6[g6];
      color.blue  = EXP5[b5];
    end else begin
      color.red   = hold0;
      color.green = hold1;
      color.blue  = last_byte;
    end
  end

endmodule

// ===== rtl/spilcd_decoder.sv =====
// Command and data decoder: controller state, window, cursor and frame hash.
module spilcd_decoder
  import spilcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  step_t      step_i,
  input  seed_load_t seed_i,
  output result_t    res_o
);

  logic [7:0]  opcode_r, opcode_nxt;
  logic [4:0]  seen_r, seen_nxt;
  logic [7:0]  pw_r [4];
  logic [7:0]  pw_nxt [4];
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  hold_r [2];
  logic [7:0]  hold_nxt [2];
  logic [15:0] x0_r, x1_r, y0_r, y1_r;
  logic [15:0] x0_nxt, x1_nxt, y0_nxt, y1_nxt;
  logic [15:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic [7:0]  madctl_r, madctl_nxt;
  logic [7:0]  colmod_r, colmod_nxt;
  logic        sleep_r, sleep_nxt;
  logic        disp_r, disp_nxt;
  logic        inv_r, inv_nxt;
  logic [31:0] hash_r, hash_nxt;

  logic [31:0] hash_mul;
  logic [3:0]  need;
  logic        rgb565;
  logic [1:0]  pix_last;
  logic [7:0]  byte_in;
  color_t      color;

  assign byte_in  = step_i.item.spi_byte;
  assign need     = fixed_count(opcode_r);
  assign rgb565   = (colmod_r == FMT_RGB565);
  assign pix_last = rgb565 ? 2'd1 : 2'd2;
  assign hash_mul = hash_r * HASH_PRIME;

  spilcd_color u_color (
    .rgb565    (rgb565),
    .hold0     (hold_r[0]),
    .hold1     (hold_r[1]),
    .last_byte (byte_in),
    .color     (color)
  );

  always_comb begin
    opcode_nxt = opcode_r;
    seen_nxt   = seen_r;
    pw_nxt     = pw_r;
    cnt_nxt    = cnt_r;
    hold_nxt   = hold_r;
    x0_nxt     = x0_r;
    x1_nxt     = x1_r;
    y0_nxt     = y0_r;
    y1_nxt     = y1_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    madctl_nxt = madctl_r;
    colmod_nxt = colmod_r;
    sleep_nxt  = sleep_r;
    disp_nxt   = disp_r;
    inv_nxt    = inv_r;
    hash_nxt   = hash_r;
    res_o      = '0;

    if (seed_i.load) begin
      hash_nxt = seed_i.value;
    end else if (step_i.step && !step_i.item.deselected) begin
      if (step_i.item.command) begin
        opcode_nxt = byte_in;
        seen_nxt   = '0;
        cnt_nxt    = '0;
        unique case (byte_in)
          OP_RAMWR: begin
            cx_nxt = x0_r;
            cy_nxt = y0_r;
          end
          OP_SLPIN:   sleep_nxt = 1'b1;
          OP_SLPOUT:  sleep_nxt = 1'b0;
          OP_INVOFF:  inv_nxt   = 1'b0;
          OP_INVON:   inv_nxt   = 1'b1;
          OP_DISPOFF: disp_nxt  = 1'b0;
          OP_DISPON:  disp_nxt  = 1'b1;
          OP_SWRESET: begin
            sleep_nxt  = 1'b1;
            disp_nxt   = 1'b0;
            inv_nxt    = 1'b0;
            madctl_nxt = '0;
            colmod_nxt = '0;
            x0_nxt     = '0;
            x1_nxt     = FULL_X1;
            y0_nxt     = '0;
            y1_nxt     = FULL_Y1;
          end
          default: ;
        endcase
      end else if (need != 4'd0) begin
        // Parameter byte; the count saturates and only the first four bytes are kept.
        if (seen_r < PARAM_LIMIT) begin
          if (seen_r < 5'd4) begin
            pw_nxt[seen_r[1:0]] = byte_in;
          end
          seen_nxt = seen_r + 5'd1;
          if (seen_nxt == {1'b0, need}) begin
            unique case (opcode_r)
              OP_CASET: begin
                x0_nxt = {pw_nxt[0], pw_nxt[1]};
                x1_nxt = {pw_nxt[2], pw_nxt[3]};
              end
              OP_RASET: begin
                y0_nxt = {pw_nxt[0], pw_nxt[1]};
                y1_nxt = {pw_nxt[2], pw_nxt[3]};
              end
              OP_MADCTL: madctl_nxt = pw_nxt[0];
              OP_COLMOD: colmod_nxt = pw_nxt[0];
              default: ;
            endcase
          end
        end
      end else if (opcode_r == OP_RAMWR) begin
        if (cnt_r < pix_last) begin
          hold_nxt[cnt_r[0]] = byte_in;
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          res_o.pixel_valid = 1'b1;
          res_o.in_bounds   = (cx_r < SCREEN_W) && (cy_r < SCREEN_H);
          res_o.pixel_x     = cx_r;
          res_o.pixel_y     = cy_r;
          res_o.color       = color;
          hash_nxt = hash_mul ^ {8'h00, color.red, color.green, color.blue};
          cnt_nxt  = '0;
          // The cursor walks the window row by row and wraps to its origin.
          if (cx_r >= x1_r) begin
            cx_nxt = x0_r;
            cy_nxt = (cy_r >= y1_r) ? y0_r : cy_r + 16'd1;
          end else begin
            cx_nxt = cx_r + 16'd1;
          end
        end
      end
    end

    res_o.run_hash        = hash_nxt;
    res_o.sleeping        = sleep_nxt;
    res_o.display_enabled = disp_nxt;
    res_o.inverted        = inv_nxt;
    res_o.orientation     = madctl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcode_r <= '0;
      seen_r   <= '0;
      cnt_r    <= '0;
      x0_r     <= '0;
      x1_r     <= FULL_X1;
      y0_r     <= '0;
      y1_r     <= FULL_Y1;
      cx_r     <= '0;
      cy_r     <= '0;
      madctl_r <= '0;
      colmod_r <= '0;
      sleep_r  <= 1'b1;
      disp_r   <= 1'b0;
      inv_r    <= 1'b0;
      hash_r   <= HASH_SEED_RST;
    end else begin
      opcode_r <= opcode_nxt;
      seen_r   <= seen_nxt;
      cnt_r    <= cnt_nxt;
      x0_r     <= x0_nxt;
      x1_r     <= x1_nxt;
      y0_r     <= y0_nxt;
      y1_r     <= y1_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      madctl_r <= madctl_nxt;
      colmod_r <= colmod_nxt;
      sleep_r  <= sleep_nxt;
      disp_r   <= disp_nxt;
      inv_r    <= inv_nxt;
      hash_r   <= hash_nxt;
    end
  end

  // Parameter and pixel holds are always written before they are read.
  always_ff @(posedge clk) begin
    pw_r   <= pw_nxt;
    hold_r <= hold_nxt;
  end

endmodule

// ===== rtl/spi_lcd_controller_command_decoder.sv =====
// Top level of the SPI LCD command decoder: stream ports, APB register and pipeline registers.
//
//  Channel  | Direction | Transaction
//  ---------+-----------+--------------------------------------------------------------
//  in_      | slave     | one SPI byte with its command and chip-select flags
//  out_     | master    | one result per input byte: pixel fields, frame hash, mode flags
//  cfg_     | APB       | hash_seed at address 0, writing it also restarts the frame hash
//
// An input byte is captured in the input register at its acceptance edge, and its result is
// captured in the output register, raising out_tvalid, when the byte leaves the input register,
// which it cannot do while the output is stalled. A new byte is accepted every cycle while the
// output is not stalled; the controller state and 32-bit hash multiply update as the byte leaves.
// Reset is synchronous and active low and restores the full-screen window, sleep mode and
// the default hash seed. A stalled output holds its result while the input register still
// takes one more byte; after that in_tready falls until out_tready returns.
module spi_lcd_controller_command_decoder
  import spilcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] spi_byte
  input  logic [1:0]   in_tuser,   // [0] command, [1] deselected
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] in_bounds, [16:1] pixel_x, [32:17] pixel_y, [40:33] red, [48:41] green,
  // [56:49] blue, [88:57] running hash, [89] sleeping, [90] display_enabled,
  // [91] inverted, [99:92] orientation, [103:100] zero
  output logic [103:0] out_tdata,
  output logic         out_tuser,  // [0] pixel_valid
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic        in_valid_r;
  item_t       in_item_r;
  logic        out_valid_r;
  result_t     out_res_r;
  logic [31:0] seed_r;

  logic        advance;
  logic        in_accept;
  logic        cfg_wr;
  step_t       step;
  seed_load_t  seed_load;
  result_t     res;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_HASH_SEED);
  assign cfg_prdata = (cfg_paddr[2] == REG_HASH_SEED) ? seed_r : '0;

  assign step.step       = in_valid_r && advance;
  assign step.item       = in_item_r;
  assign seed_load.load  = cfg_wr;
  assign seed_load.value = cfg_pwdata;

  spilcd_decoder u_decoder (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .seed_i (seed_load),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= HASH_SEED_RST;
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (step.step) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (cfg_wr) begin
        seed_r <= cfg_pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r.spi_byte   <= in_tdata;
      in_item_r.command    <= in_tuser[0];
      in_item_r.deselected <= in_tuser[1];
    end
    if (step.step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.pixel_valid;
  assign out_tdata  = {4'h0,
                       out_res_r.orientation,
                       out_res_r.inverted,
                       out_res_r.display_enabled,
                       out_res_r.sleeping,
                       out_res_r.run_hash,
                       out_res_r.color.blue,
                       out_res_r.color.green,
                       out_res_r.color.red,
                       out_res_r.pixel_y,
                       out_res_r.pixel_x,
                       out_res_r.in_bounds};

  // A byte waiting in the input register is never dropped while the output is stalled.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r)
    else $error("input transaction lost during output stall");

  // Pixel fields are zero when the byte completed no pixel.
  a_no_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[56:0] == 57'd0)
    else $error("pixel fields set without a completed pixel");

  // An in-bounds pixel really lies on the screen.
  a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tdata[16:1] < SCREEN_W) && (out_tdata[32:17] < SCREEN_H))
    else $error("in_bounds flag set outside the screen");

  // A result register is loaded only from a byte held in the input register.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r && advance |=> !out_tvalid)
    else $error("result transaction without an input transaction");

endmodule

// ===== sim/tb_spi_lcd_controller_command_decoder.sv =====
// Self-checking testbench for the SPI LCD command decoder: directed and random byte streams.
module tb_spi_lcd_controller_command_decoder;
  import spilcd_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // [7:0] spi_byte
  logic [1:0]   in_tuser;   // [0] command, [1] deselected
  logic         out_tvalid;
  logic         out_tready;
  // [0] in_bounds, [16:1] pixel_x, [32:17] pixel_y, [40:33] red, [48:41] green,
  // [56:49] blue, [88:57] running hash, [89] sleeping, [90] display_enabled,
  // [91] inverted, [99:92] orientation, [103:100] zero
  logic [103:0] out_tdata;
  logic         out_tuser;  // [0] pixel_valid
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  spi_lcd_controller_command_decoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  localparam logic [5:0][7:0] MODE_OPS = {OP_SLPIN, OP_SLPOUT, OP_INVOFF, OP_INVON,
                                          OP_DISPOFF, OP_DISPON};
  localparam logic [12:0][7:0] PARAM_ONLY_OPS = {OP_VSCRDEF, OP_VSCSAD, OP_FRMCTR1, OP_INVCTR,
                                                 OP_DFUNCTR, OP_ETMOD, OP_PWCTR1, OP_PWCTR2,
                                                 OP_VMCTR1, OP_VMOFCTR, OP_PGAMCTRL,
                                                 OP_NGAMCTRL, OP_PUMPCTL};

  // Controller state as the predictor sees it.
  logic [7:0]  lcd_opcode      = 8'h00;
  logic [4:0]  lcd_params_seen = 5'd0;
  logic [7:0]  lcd_params [4];
  logic [1:0]  lcd_pix_count   = 2'd0;
  logic [7:0]  lcd_pix_hold [2];
  logic [15:0] lcd_x0 = 16'd0;
  logic [15:0] lcd_x1 = FULL_X1;
  logic [15:0] lcd_y0 = 16'd0;
  logic [15:0] lcd_y1 = FULL_Y1;
  logic [15:0] lcd_cur_x  = 16'd0;
  logic [15:0] lcd_cur_y  = 16'd0;
  logic [7:0]  lcd_madctl = 8'h00;
  logic [7:0]  lcd_colmod = 8'h00;
  logic        lcd_sleep  = 1'b1;
  logic        lcd_disp   = 1'b0;
  logic        lcd_inv    = 1'b0;
  logic [31:0] lcd_hash   = HASH_SEED_RST;

  result_t pending_results [$];
  int      mismatches    = 0;
  int      live_sent     = 0;
  int      send_idle_pct = 22;
  int      recv_idle_pct = 69;
  logic    add_noise     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 400000);
    $display("Verification failed");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int op_param_len(input logic [7:0] op);
    case (op)
      OP_CASET, OP_RASET, OP_PUMPCTL:                   return 4;
      OP_MADCTL, OP_COLMOD, OP_INVCTR, OP_ETMOD,
      OP_PWCTR2, OP_VMOFCTR:                            return 1;
      OP_VSCRDEF:                                       return 6;
      OP_VSCSAD, OP_FRMCTR1, OP_PWCTR1:                 return 2;
      OP_DFUNCTR, OP_VMCTR1:                            return 3;
      OP_PGAMCTRL, OP_NGAMCTRL:                         return 15;
      default:                                          return 0;
    endcase
  endfunction

  function automatic void apply_params();
    logic [15:0] first_word;
    logic [15:0] second_word;
    first_word  = {lcd_params[0], lcd_params[1]};
    second_word = {lcd_params[2], lcd_params[3]};
    case (lcd_opcode)
      OP_CASET: begin
        lcd_x0 = first_word;
        lcd_x1 = second_word;
      end
      OP_RASET: begin
        lcd_y0 = first_word;
        lcd_y1 = second_word;
      end
      OP_MADCTL: lcd_madctl = lcd_params[0];
      OP_COLMOD: lcd_colmod = lcd_params[0];
      default: ;
    endcase
  endfunction

  // Advances the predicted controller state by one byte and returns the result it causes.
  function automatic result_t decode_byte(input logic [7:0] b, input logic cmd,
                                          input logic desel);
    result_t     r;
    int          need;
    int          width;
    logic [15:0] word;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    r = '0;
    if (!desel && cmd) begin
      lcd_opcode      = b;
      lcd_params_seen = 5'd0;
      lcd_pix_count   = 2'd0;
      case (b)
        OP_RAMWR: begin
          lcd_cur_x = lcd_x0;
          lcd_cur_y = lcd_y0;
        end
        OP_SLPIN:   lcd_sleep = 1'b1;
        OP_SLPOUT:  lcd_sleep = 1'b0;
        OP_INVOFF:  lcd_inv   = 1'b0;
        OP_INVON:   lcd_inv   = 1'b1;
        OP_DISPOFF: lcd_disp  = 1'b0;
        OP_DISPON:  lcd_disp  = 1'b1;
        OP_SWRESET: begin
          lcd_sleep  = 1'b1;
          lcd_disp   = 1'b0;
          lcd_inv    = 1'b0;
          lcd_madctl = 8'h00;
          lcd_colmod = 8'h00;
          lcd_x0     = 16'd0;
          lcd_x1     = FULL_X1;
          lcd_y0     = 16'd0;
          lcd_y1     = FULL_Y1;
        end
        default: ;
      endcase
    end else if (!desel) begin
      need  = op_param_len(lcd_opcode);
      width = (lcd_colmod == FMT_RGB565) ? 2 : 3;
      if (need != 0) begin
        // Bytes past the parameter store are dropped without effect.
        if (lcd_params_seen < PARAM_LIMIT) begin
          if (lcd_params_seen < 5'd4) lcd_params[lcd_params_seen[1:0]] = b;
          lcd_params_seen = lcd_params_seen + 5'd1;
          if (int'(lcd_params_seen) == need) apply_params();
        end
      end else if (lcd_opcode == OP_RAMWR) begin
        if (int'(lcd_pix_count) + 1 < width) begin
          lcd_pix_hold[lcd_pix_count[0]] = b;
          lcd_pix_count = lcd_pix_count + 2'd1;
        end else begin
          if (width == 2) begin
            word  = {lcd_pix_hold[0], b};
            red   = 8'((int'(word[15:11]) * 255 + 15) / 31);
            green = 8'((int'(word[10:5]) * 255 + 31) / 63);
            blue  = 8'((int'(word[4:0]) * 255 + 15) / 31);
          end else begin
            red   = lcd_pix_hold[0];
            green = lcd_pix_hold[1];
            blue  = b;
          end
          r.pixel_valid = 1'b1;
          r.in_bounds   = (lcd_cur_x < SCREEN_W) && (lcd_cur_y < SCREEN_H);
          r.pixel_x     = lcd_cur_x;
          r.pixel_y     = lcd_cur_y;
          r.color.red   = red;
          r.color.green = green;
          r.color.blue  = blue;
          lcd_hash      = (lcd_hash * HASH_PRIME) ^ {8'h00, red, green, blue};
          lcd_pix_count = 2'd0;
          if (lcd_cur_x >= lcd_x1) begin
            lcd_cur_x = lcd_x0;
            if (lcd_cur_y >= lcd_y1) lcd_cur_y = lcd_y0;
            else lcd_cur_y = lcd_cur_y + 16'd1;
          end else begin
            lcd_cur_x = lcd_cur_x + 16'd1;
          end
        end
      end
    end
    r.run_hash        = lcd_hash;
    r.sleeping        = lcd_sleep;
    r.display_enabled = lcd_disp;
    r.inverted        = lcd_inv;
    r.orientation     = lcd_madctl;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pending_results.push_back(decode_byte(in_tdata, in_tuser[0], in_tuser[1]));
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: result transaction with no byte outstanding, data %h",
                     $realtime, out_tdata);
        end else begin
          want = pending_results.pop_front();
          compare_field("pixel_valid", want.pixel_valid, out_tuser);
          compare_field("in_bounds", want.in_bounds, out_tdata[0]);
          compare_field("pixel_x", want.pixel_x, out_tdata[16:1]);
          compare_field("pixel_y", want.pixel_y, out_tdata[32:17]);
          compare_field("red", want.color.red, out_tdata[40:33]);
          compare_field("green", want.color.green, out_tdata[48:41]);
          compare_field("blue", want.color.blue, out_tdata[56:49]);
          compare_field("running hash", want.run_hash, out_tdata[88:57]);
          compare_field("sleeping", want.sleeping, out_tdata[89]);
          compare_field("display_enabled", want.display_enabled, out_tdata[90]);
          compare_field("inverted", want.inverted, out_tdata[91]);
          compare_field("orientation", want.orientation, out_tdata[99:92]);
          compare_field("padding", 32'd0, out_tdata[103:100]);
        end
      end
    end
  end

  // Entered and left at a falling edge; valid stays high into the next call.
  task automatic send_byte(input logic [7:0] b, input logic cmd, input logic desel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = {desel, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!desel) live_sent++;
    @(negedge clk);
  endtask

  task automatic put_byte(input logic [7:0] b, input logic cmd);
    // Random traffic sprinkles bytes sent with chip select high.
    if (add_noise && $urandom_range(19) == 0)
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    send_byte(b, cmd, 1'b0);
  endtask

  task automatic send_command(input logic [7:0] op);
    put_byte(op, 1'b1);
  endtask

  task automatic send_param(input logic [7:0] b);
    put_byte(b, 1'b0);
  endtask

  task automatic wait_for_results();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_hash_seed(input logic [31:0] value);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {REG_HASH_SEED, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    lcd_hash = value;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic test_mode_commands();
    send_byte(OP_SLPOUT, 1'b1, 1'b1);
    send_command(OP_SLPOUT);
    send_command(OP_DISPON);
    send_command(OP_INVON);
    // An opcode the controller does not know swallows its data bytes.
    send_command(8'h00);
    send_param(8'h5a);
    send_command(OP_INVOFF);
    send_command(OP_DISPOFF);
    send_command(OP_SLPIN);
  endtask

  task automatic test_parameters();
    send_command(OP_MADCTL);
    send_param(8'hff);
    send_command(OP_COLMOD);
    send_param(FMT_RGB565);
    // Column window 319..320 with one excess byte, which must be ignored.
    send_command(OP_CASET);
    send_param(8'h01);
    send_param(8'h3f);
    send_param(8'h01);
    send_param(8'h40);
    send_param(8'hff);
    send_command(OP_VSCSAD);
    send_param(8'h12);
    send_param(8'h34);
  endtask

  task automatic test_pixel_formats();
    // Two RGB565 pixels straddle the screen edge, then the cursor wraps to the next row.
    send_command(OP_RAMWR);
    send_param(8'hff);
    send_param(8'hff);
    send_param(8'h00);
    send_param(8'h00);
    send_param(8'hf8);
    send_param(8'h1f);
    send_command(OP_COLMOD);
    send_param(8'h66);
    send_command(OP_RAMWR);
    send_param(8'h12);
    send_param(8'h80);
    send_param(8'hff);
    send_command(OP_SWRESET);
  endtask

  task automatic random_sequence();
    int          kind;
    int          sel;
    int          count;
    logic [7:0]  op;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [31:0] bounds;
    kind = $urandom_range(99);
    if (kind < 10) begin
      send_command(8'($urandom_range(255)));
      repeat ($urandom_range(3)) send_param(8'($urandom_range(255)));
    end else if (kind < 20) begin
      send_command(MODE_OPS[$urandom_range(5)]);
    end else if (kind < 22) begin
      send_command(OP_SWRESET);
    end else if (kind < 36) begin
      sel = $urandom_range(9);
      lo  = 16'($urandom_range(330));
      if (sel < 6) hi = lo + 16'($urandom_range(6));
      else if (sel < 8) hi = 16'($urandom_range(330));
      else if (sel == 8) begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end else begin
        lo = 16'd0;
        hi = FULL_X1;
      end
      bounds = {lo, hi};
      send_command($urandom_range(1) ? OP_CASET : OP_RASET);
      count = ($urandom_range(9) < 8) ? 4 : $urandom_range(18);
      for (int i = 0; i < count; i++)
        send_param((i < 4) ? bounds[31 - 8 * i -: 8] : 8'($urandom_range(255)));
    end else if (kind < 42) begin
      send_command(OP_MADCTL);
      send_param(8'($urandom_range(255)));
    end else if (kind < 50) begin
      send_command(OP_COLMOD);
      send_param($urandom_range(1) ? FMT_RGB565 : 8'($urandom_range(255)));
    end else if (kind < 60) begin
      op = PARAM_ONLY_OPS[$urandom_range(12)];
      send_command(op);
      count = op_param_len(op) + $urandom_range(3) - 1;
      if ($urandom_range(9) == 0) count = $urandom_range(20);
      repeat (count) send_param(8'($urandom_range(255)));
    end else begin
      send_command(OP_RAMWR);
      repeat ($urandom_range(1, 36)) send_param(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input logic [31:0] seed, input int count);
    int target;
    wait_for_results();
    write_hash_seed(seed);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    add_noise     = 1'b1;
    target        = live_sent + count;
    while (live_sent < target) random_sequence();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = 2'b00;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = 3'd0;
    cfg_pwdata  = 32'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_mode_commands();
    test_parameters();
    test_pixel_formats();
    run_random_phase(22, 69, 32'h0000_0000, 430);
    run_random_phase(69, 22, 32'hffff_ffff, 430);
    run_random_phase(0, 0, $urandom, 430);
    wait_for_results();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spilcd_pkg.sv
rtl/spilcd_color.sv
rtl/spilcd_decoder.sv
rtl/spi_lcd_controller_command_decoder.sv
sim/tb_spi_lcd_controller_command_decoder.sv
